// File: rtl/assert_macros.svh
// assertion macros for the scan sequencer rtl
// sampled on aclk, disabled while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check with reset disable
`define DSSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// same-cycle implication built on the macro above
`define DSSS_ASSERT_IMPL(label, ante, cons, msg) \
    `DSSS_ASSERT(label, (ante) |-> (cons), msg)

`endif

// File: rtl/dsss_pkg.sv
// shared types and constants of the dual stepper scan sequencer
// no dependencies
package dsss_pkg;

    localparam int NUM_POSITIONS_DEF = 8;

    localparam int KIND_W      = 4;
    localparam int MODE_W      = 3;
    localparam int TBL_IDX_W   = 3;
    localparam int STEPS_W     = 8;
    localparam int POS_OUT_W   = 3;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;
    localparam int M_PAYLOAD_W = 19;

    localparam logic [KIND_W-1:0] KIND_SERVICE = 4'd0;
    localparam logic [KIND_W-1:0] KIND_START   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_STOP    = 4'd2;
    localparam logic [KIND_W-1:0] KIND_M1_HOME = 4'd3;
    localparam logic [KIND_W-1:0] KIND_M1_END  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_M2_HOME = 4'd5;
    localparam logic [KIND_W-1:0] KIND_M2_END  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_TICK    = 4'd7;
    localparam logic [KIND_W-1:0] KIND_MODE    = 4'd8;
    localparam logic [KIND_W-1:0] KIND_LOAD    = 4'd9;

    typedef enum logic [MODE_W-1:0] {
        MODE_STANDBY = 3'd0,
        MODE_FULL    = 3'd1,
        MODE_MEASURE = 3'd2,
        MODE_MOVE    = 3'd3,
        MODE_RETURN  = 3'd4,
        MODE_END     = 3'd5
    } mode_t;

    typedef logic [STEPS_W-1:0] steps_t;

endpackage

// File: rtl/dual_stepper_scan_sequencer.sv
// Dual stepper scan sequencer.
// Slave channel s_*: one event item per handshake, kind in s_tuser, arguments in s_tdata.
// Master channel m_*: exactly one result item per event item, in order.
// Every accepted item goes to an input register; once the result register is empty or
// being taken, the sequencer state and the result register are updated together from
// it, so a result passes the input register and then the result register to m_tvalid.
// Throughput is one item per cycle unless m_tready is held low: s_tready stays high while
// the result register is empty or is being taken, so a new item enters while a result waits.
// When the receiver holds m_tready low, one result and one item in the input register
// are held, then s_tready falls until the receiver takes the result.
// The step table holds min(NUM_POSITIONS, 8) entries in flip-flops; an entry that was
// never loaded reads as an arbitrary value.
// Synchronous reset (aresetn low) empties both registers and returns the scan state to
// standby at position 0 with the timer stopped; the step table keeps its contents.
// Depends on dsss_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dual_stepper_scan_sequencer #(
    parameter int NUM_POSITIONS = dsss_pkg::NUM_POSITIONS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // m1_home_level, m2_home_level, mode_value[2:0], table_index[2:0], table_steps[7:0]
    input  logic [dsss_pkg::S_TDATA_W-1:0] s_tdata,
    // kind[3:0]
    input  logic [dsss_pkg::KIND_W-1:0]    s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pulse_m1, pulse_m2, toward_end, burst_length[7:0], measure_request,
    // mode_now[2:0], position_now[2:0], timer_on, zero padding
    output logic [dsss_pkg::M_TDATA_W-1:0] m_tdata
);
    import dsss_pkg::*;

    localparam int POS_W     = $clog2(NUM_POSITIONS);
    localparam int TBL_DEPTH = (NUM_POSITIONS < (1 << TBL_IDX_W)) ?
                               NUM_POSITIONS : (1 << TBL_IDX_W);
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam logic [POS_W-1:0]     LAST_POS  = POS_W'(NUM_POSITIONS - 1);
    localparam logic [POS_W-1:0]     FIRST_POS = '0;
    localparam logic [TBL_IDX_W:0]   TBL_LIMIT = (TBL_IDX_W + 1)'(TBL_DEPTH);

    // input register
    logic                  in_vld_reg;
    logic [KIND_W-1:0]     in_kind_reg;
    logic                  in_h1_reg;
    logic                  in_h2_reg;
    logic [MODE_W-1:0]     in_mode_reg;
    logic [TBL_IDX_W-1:0]  in_idx_reg;
    steps_t                in_steps_reg;

    // sequencer state
    mode_t                 mode_reg, mode_next;
    logic                  inward_reg, inward_next;
    logic                  granted_reg, granted_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [1:0]            late_reg, late_next;
    logic [1:0]            home_reg, home_next;
    logic [1:0]            end_reg, end_next;
    logic                  timer_reg, timer_next;
    steps_t                tbl_reg [TBL_DEPTH];

    // result register
    logic                  out_vld_reg;
    logic                  out_p1_reg, out_p1_next;
    logic                  out_p2_reg, out_p2_next;
    logic                  out_dir_reg, out_dir_next;
    steps_t                out_len_reg, out_len_next;
    logic                  out_meas_reg, out_meas_next;

    logic                  advance;
    logic                  can_in;
    logic                  can_out;
    steps_t                burst;
    logic                  tbl_wr;
    logic [POS_W+POS_OUT_W-1:0] out_pos_ext;
    logic [POS_W-1:0]      out_pos_reg;
    mode_t                 out_mode_reg;
    logic                  out_timer_reg;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign m_tvalid = out_vld_reg;

    assign can_in  = inward_reg && (pos_reg != LAST_POS);
    assign can_out = !inward_reg && (pos_reg != FIRST_POS);
    assign burst   = tbl_reg[pos_reg[TBL_AW-1:0]];
    assign tbl_wr  = advance && (in_kind_reg == KIND_LOAD) && ({1'b0, in_idx_reg} < TBL_LIMIT);

    always_comb begin
        mode_next     = mode_reg;
        inward_next   = inward_reg;
        granted_next  = granted_reg;
        pos_next      = pos_reg;
        late_next     = late_reg;
        home_next     = home_reg;
        end_next      = end_reg;
        timer_next    = timer_reg;
        out_p1_next   = 1'b0;
        out_p2_next   = 1'b0;
        out_dir_next  = 1'b0;
        out_len_next  = '0;
        out_meas_next = 1'b0;
        case (in_kind_reg)
            KIND_SERVICE: begin
                case (mode_reg)
                    MODE_FULL, MODE_MOVE: begin
                        if (granted_reg && (can_in || can_out)) begin
                            if (late_reg == 2'b01) begin
                                out_p1_next  = 1'b1;
                                out_dir_next = inward_reg;
                                out_len_next = burst;
                            end else if (late_reg == 2'b10) begin
                                out_p2_next  = 1'b1;
                                out_dir_next = inward_reg;
                                out_len_next = burst;
                            end else if (late_reg == 2'b00) begin
                                out_p1_next   = 1'b1;
                                out_p2_next   = 1'b1;
                                out_dir_next  = inward_reg;
                                out_len_next  = burst;
                                out_meas_next = (mode_reg == MODE_FULL);
                                pos_next      = can_in ? pos_reg + 1'b1 : pos_reg - 1'b1;
                            end
                            granted_next = 1'b0;
                        end
                        if (pos_next == LAST_POS) begin
                            inward_next = 1'b0;
                        end else if ((pos_next == FIRST_POS) && (end_reg == 2'b11)) begin
                            mode_next = MODE_END;
                        end
                    end
                    MODE_MEASURE: begin
                        out_meas_next = 1'b1;
                        mode_next     = MODE_STANDBY;
                    end
                    MODE_RETURN: begin
                        inward_next = 1'b0;
                        if (in_h1_reg && in_h2_reg) begin
                            mode_next = MODE_STANDBY;
                        end else begin
                            out_p1_next = !home_reg[0] && !in_h1_reg;
                            out_p2_next = !home_reg[1] && !in_h2_reg;
                            if (out_p1_next || out_p2_next) begin
                                out_len_next = burst;
                            end
                        end
                    end
                    MODE_END: begin
                        timer_next   = 1'b0;
                        granted_next = 1'b0;
                        home_next    = 2'b00;
                        end_next     = 2'b00;
                        mode_next    = MODE_STANDBY;
                    end
                    default: begin
                    end
                endcase
            end
            KIND_START: begin
                mode_next    = MODE_FULL;
                timer_next   = 1'b1;
                inward_next  = 1'b1;
                granted_next = 1'b1;
                pos_next     = FIRST_POS;
                late_next    = 2'b00;
            end
            KIND_STOP: begin
                mode_next = MODE_END;
            end
            KIND_M1_HOME, KIND_M2_HOME: begin
                home_next = home_reg | ((in_kind_reg == KIND_M1_HOME) ? 2'b01 : 2'b10);
                if ((in_h1_reg || in_h2_reg) && (end_reg == 2'b11)) begin
                    mode_next = MODE_END;
                end
            end
            KIND_M1_END, KIND_M2_END: begin
                late_next = late_reg | ((in_kind_reg == KIND_M1_END) ? 2'b10 : 2'b01);
                end_next  = end_reg | ((in_kind_reg == KIND_M1_END) ? 2'b01 : 2'b10);
                if (end_next == 2'b11) begin
                    late_next   = 2'b00;
                    inward_next = 1'b0;
                end
            end
            KIND_TICK: begin
                if (timer_reg) begin
                    granted_next = 1'b1;
                end
            end
            KIND_MODE: begin
                if (in_mode_reg <= MODE_END) begin
                    mode_next = mode_t'(in_mode_reg);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg  <= s_tuser;
            in_h1_reg    <= s_tdata[0];
            in_h2_reg    <= s_tdata[1];
            in_mode_reg  <= s_tdata[4:2];
            in_idx_reg   <= s_tdata[7:5];
            in_steps_reg <= s_tdata[15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_STANDBY;
            inward_reg  <= 1'b0;
            granted_reg <= 1'b0;
            pos_reg     <= FIRST_POS;
            late_reg    <= 2'b00;
            home_reg    <= 2'b00;
            end_reg     <= 2'b00;
            timer_reg   <= 1'b0;
        end else if (advance) begin
            mode_reg    <= mode_next;
            inward_reg  <= inward_next;
            granted_reg <= granted_next;
            pos_reg     <= pos_next;
            late_reg    <= late_next;
            home_reg    <= home_next;
            end_reg     <= end_next;
            timer_reg   <= timer_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tbl_wr) begin
            tbl_reg[in_idx_reg[TBL_AW-1:0]] <= in_steps_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_p1_reg    <= out_p1_next;
            out_p2_reg    <= out_p2_next;
            out_dir_reg   <= out_dir_next;
            out_len_reg   <= out_len_next;
            out_meas_reg  <= out_meas_next;
            out_mode_reg  <= mode_next;
            out_pos_reg   <= pos_next;
            out_timer_reg <= timer_next;
        end
    end

    assign out_pos_ext = {{POS_OUT_W{1'b0}}, out_pos_reg};

    assign m_tdata = {(M_TDATA_W - M_PAYLOAD_W)'(0), out_timer_reg, out_pos_ext[POS_OUT_W-1:0],
                      out_mode_reg, out_meas_reg, out_len_reg, out_dir_reg,
                      out_p2_reg, out_p1_reg};

    // scan position moves only when an item is processed
    `DSSS_ASSERT(a_pos_hold, !advance |=> $stable(pos_reg), "position changed without an item")

    // a measurement after a move means both motors stepped
    `DSSS_ASSERT_IMPL(a_meas_both, out_vld_reg && out_meas_reg && (out_p1_reg || out_p2_reg),
        out_p1_reg && out_p2_reg, "measurement requested after a single-motor move")

    // a tick with the timer stopped leaves the move grant alone
    `DSSS_ASSERT(a_tick_idle, advance && (in_kind_reg == KIND_TICK) && !timer_reg |=>
        $stable(granted_reg), "tick granted a move with the timer stopped")

    // the position never passes the last entry of the scan
    `DSSS_ASSERT_IMPL(a_pos_range, 1'b1, pos_reg <= LAST_POS, "position beyond the last entry")

    // padding bits at the top of the result item stay clear
    `DSSS_ASSERT_IMPL(a_pad_zero, out_vld_reg, m_tdata[M_TDATA_W-1:M_PAYLOAD_W] == '0,
        "padding bits of the result item are not zero")

endmodule
